@@ hdl/wbm_pkg.sv @@
// ----------------------------------------------------------------------------
// wbm_pkg
// Shared types and codes for the wraparound byte memory.
// ----------------------------------------------------------------------------
package wbm_pkg;

	// Access word carried between the sequencer and the address reduction unit.
	typedef logic [31:0] word_t;

	// Operation codes of one transaction.
	typedef logic [1:0] op_t;
	localparam op_t OP_LOAD  = 2'd0;
	localparam op_t OP_STORE = 2'd1;
	localparam op_t OP_MARK  = 2'd2;
	localparam op_t OP_NONE  = 2'd3;

	// Byte count field and the widest access.
	typedef logic [2:0] count_t;
	localparam count_t WORD_BYTES = 3'd4;

	// Packed width of the input stream data, rounded up to whole bytes.
	localparam int IN_BITS  = 77;
	localparam int IN_BYTES = (IN_BITS + 7) / 8;

endpackage

@@ hdl/wbm_ram.sv @@
// ----------------------------------------------------------------------------
// wbm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wbm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/wbm_addr_reduce.sv @@
// ----------------------------------------------------------------------------
// wbm_addr_reduce
// Four-stage pipeline that reduces a signed 32-bit address modulo the memory
// size by a reciprocal multiplication with one correction step.
// ----------------------------------------------------------------------------
module wbm_addr_reduce #(
	parameter int MEMORY_BYTES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  wbm_pkg::word_t                  address,
	output logic                            out_valid,
	output logic [$clog2(MEMORY_BYTES)-1:0] out_addr
);

	import wbm_pkg::*;

	localparam int AW = $clog2(MEMORY_BYTES);
	localparam int K  = 31 + AW;
	// Floor reciprocal; the quotient estimate is at most one below the true one.
	localparam logic [63:0] RECIP_FULL = (64'd1 << K) / 64'(MEMORY_BYTES);
	localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
	localparam logic [31:0] MEM32      = 32'(MEMORY_BYTES);
	localparam logic [AW:0] MEM_W      = (AW + 1)'(MEMORY_BYTES);
	// A negative address weighs 2^32 less than its unsigned pattern, which
	// amounts to adding (M - 2^32 mod M) mod M to the unsigned remainder.
	localparam int          WRAP_REM   = int'((64'd1 << 32) % 64'(MEMORY_BYTES));
	localparam int          NEG_ADD    = (WRAP_REM == 0) ? 0 : MEMORY_BYTES - WRAP_REM;
	localparam logic [AW:0] NEG_W      = (AW + 1)'(NEG_ADD);

	logic          v_s1, v_s2, v_s3;
	word_t         x_s1, x_s2;
	logic [63:0]   prod_s1;
	word_t         qm_s2;
	logic [AW-1:0] r_s3;
	logic          neg_s3;

	word_t         quot;
	word_t         diff;
	logic [AW:0]   diff_lo;
	logic [AW:0]   rem_fix;
	logic [AW:0]   sum;
	logic [AW:0]   sum_fix;

	assign quot    = 32'(prod_s1 >> K);
	assign diff    = x_s2 - qm_s2;
	assign diff_lo = diff[AW:0];
	assign rem_fix = (diff_lo >= MEM_W) ? diff_lo - MEM_W : diff_lo;
	assign sum     = {1'b0, r_s3} + (neg_s3 ? NEG_W : '0);
	assign sum_fix = (sum >= MEM_W) ? sum - MEM_W : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1     <= address;
		prod_s1  <= {32'd0, address} * {32'd0, RECIP};
		x_s2     <= x_s1;
		qm_s2    <= quot * MEM32;
		r_s3     <= rem_fix[AW-1:0];
		neg_s3   <= x_s2[31];
		out_addr <= sum_fix[AW-1:0];
	end

endmodule

@@ hdl/wraparound_byte_memory.sv @@
// ----------------------------------------------------------------------------
// wraparound_byte_memory
// Byte-addressed circular memory with a parallel store of mark bytes.
// ----------------------------------------------------------------------------
// Flow: after acceptance, a transaction passes the address reduction and then
// its byte loop; a load then hands its result to the output register.
// One transaction is in flight at a time, the next taken once it is done,
// with byte_count saturated and zero for the unused code. The four-stage
// address reduction and the single RAM port, one byte a cycle, set its pace.
// Reset: after arst_n is released, a clearing pass writes zero to all
// MEMORY_BYTES entries, one a cycle, before the first transaction is taken.
// ----------------------------------------------------------------------------
module wraparound_byte_memory #(
	parameter int MEMORY_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream. s_tdata from bit 0 up: op[1:0], address[31:0],
	// byte_count[2:0], store_value[31:0], mark_value[7:0], zero fill.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [wbm_pkg::IN_BYTES*8-1:0] s_tdata,
	// Output stream. m_tdata from bit 0 up: load_data[31:0].
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata
);

	import wbm_pkg::*;

	localparam int            AW       = $clog2(MEMORY_BYTES);
	localparam logic [AW-1:0] MEM_LAST = AW'(MEMORY_BYTES - 1);

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_REDUCE = 3'd2;
	localparam logic [2:0] ST_ACCESS = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	// Input fields as they sit in the packed stream data.
	op_t    in_op;
	word_t  in_address;
	count_t in_count;
	word_t  in_store;
	logic [7:0] in_mark;

	assign in_op      = s_tdata[1:0];
	assign in_address = s_tdata[33:2];
	assign in_count   = s_tdata[36:34];
	assign in_store   = s_tdata[68:37];
	assign in_mark    = s_tdata[76:69];

	// Control state.
	logic [2:0]    state_q;
	logic [AW-1:0] clr_addr_q;
	logic          red_start_q;
	count_t        issued_q;
	logic          rd_v_s1;
	logic          out_valid_q;

	// Payload of the transaction in flight.
	op_t           op_q;
	count_t        count_q;
	word_t         raw_addr_q;
	word_t         store_sh_q;
	logic [7:0]    mark_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] addr_s1;
	word_t         acc_q;
	word_t         out_data_q;

	logic          accept;
	count_t        sat_count;
	logic [5:0]    store_shift;
	logic          issue;
	logic          access_done;
	logic          out_load;
	logic          red_v;
	logic [AW-1:0] red_addr;
	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic [15:0]   ram_wr_data;
	logic [15:0]   ram_rd_data;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Counts above a word saturate; the unused op code touches nothing.
	assign sat_count   = (in_op == OP_NONE) ? '0 :
	                     ((in_count > WORD_BYTES) ? WORD_BYTES : in_count);
	// Left-justify the stored bytes so the most significant one goes out first.
	assign store_shift = {WORD_BYTES - sat_count, 3'b000};

	assign issue       = (state_q == ST_ACCESS) && (issued_q != count_q);
	assign access_done = (state_q == ST_ACCESS) && !issue && !rd_v_s1;
	assign out_load    = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	// The address reduction runs as its own pipeline, fed by a start pulse.
	wbm_addr_reduce #(
		.MEMORY_BYTES(MEMORY_BYTES)
	) u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (red_start_q),
		.address  (raw_addr_q),
		.out_valid(red_v),
		.out_addr (red_addr)
	);

	// Each RAM entry holds the mark byte above the data byte. Every byte of an
	// access is read first; a store or a mark writes the entry back in the cycle
	// after its read with the other half kept. The access covers at most four
	// distinct entries, so the write-back never meets the read of the same entry.
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = addr_s1;
		ram_wr_data = ram_rd_data;
		if (state_q == ST_CLEAR) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_addr_q;
			ram_wr_data = '0;
		end else if (rd_v_s1) begin
			if (op_q == OP_STORE) begin
				ram_wr_en   = 1'b1;
				ram_wr_data = {ram_rd_data[15:8], store_sh_q[31:24]};
			end else if (op_q == OP_MARK) begin
				ram_wr_en   = 1'b1;
				ram_wr_data = {mark_q, ram_rd_data[7:0]};
			end
		end
	end

	wbm_ram #(
		.WIDTH(16),
		.DEPTH(MEMORY_BYTES)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (issue),
		.rd_addr(addr_q),
		.rd_data(ram_rd_data)
	);

	// Sequencer: clearing pass, address reduction, byte loop, result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			red_start_q <= 1'b0;
			issued_q    <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			red_start_q <= accept;
			rd_v_s1     <= issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == MEM_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					issued_q <= '0;
					if (red_v) begin
						state_q <= ST_ACCESS;
					end
				end
				ST_ACCESS: begin
					if (issue) begin
						issued_q <= issued_q + 1'b1;
					end
					if (access_done) begin
						state_q <= (op_q == OP_LOAD) ? ST_OUT : ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= in_op;
			count_q    <= sat_count;
			raw_addr_q <= in_address;
			store_sh_q <= in_store << store_shift;
			mark_q     <= in_mark;
			acc_q      <= '0;
		end
		if ((state_q == ST_REDUCE) && red_v) begin
			addr_q <= red_addr;
		end else if (issue) begin
			addr_q <= (addr_q == MEM_LAST) ? '0 : addr_q + 1'b1;
		end
		addr_s1 <= addr_q;
		if (rd_v_s1) begin
			acc_q      <= {acc_q[23:0], ram_rd_data[7:0]};
			store_sh_q <= {store_sh_q[23:0], 8'd0};
		end
		if (out_load) begin
			out_data_q <= acc_q;
		end
	end

	// The write-back of one byte never targets the entry being read.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && issue) |-> (ram_wr_addr != addr_q))
		else $error("write-back collides with a read of the same entry");

	// The byte loop never issues more reads than the access covers.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCESS) |-> (issued_q <= count_q))
		else $error("byte loop ran past the access length");

	// Only a load reaches the result hand-off.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (op_q == OP_LOAD))
		else $error("result hand-off reached by a non-load");

	// The reduced address always lies inside the memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		red_v |-> (red_addr <= MEM_LAST))
		else $error("reduced address outside the memory");

	// A result register is refilled only after its previous result was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> $stable(out_data_q))
		else $error("pending result overwritten");

endmodule
